[src/trapezoid_integrator_assert.svh]
// Assertion macros for the trapezoid integrator.
// Included by the top level; relies on aclk and aresetn in the including scope.
`ifndef TRAPEZOID_INTEGRATOR_ASSERT_SVH
`define TRAPEZOID_INTEGRATOR_ASSERT_SVH

// Same-cycle implication checked on every active clock edge.
`define TI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("trapezoid_integrator: same-cycle check failed");

// Next-cycle implication checked on every active clock edge.
`define TI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("trapezoid_integrator: next-cycle check failed");

`endif

[src/ti_pkg.sv]
// Shared types and constants for the trapezoid integrator.
// Used by the controller, the datapath, the divider and the top level.
package ti_pkg;

    localparam int LimitWidth  = 24;
    localparam int CountBits   = 16;
    localparam int FracBits    = 16;
    localparam int FxBits      = 30;
    localparam int ResultWidth = 32;
    localparam int QuotWidth   = 31;
    localparam int CntWidth    = $clog2(QuotWidth);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_X,
        ST_SQ,
        ST_F_GO,
        ST_F_WAIT,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_STEP,
        DIV_INTEG,
        DIV_MEAN
    } div_op_t;

    typedef struct packed {
        logic    load_in;
        logic    div_start;
        div_op_t div_op;
        logic    latch_step;
        logic    calc_x;
        logic    calc_sq;
        logic    accum;
        logic    latch_mean;
        logic    calc_prod;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic div_done;
        logic div_busy;
        logic last_sample;
        logic out_busy;
    } sts_t;

endpackage

[src/ti_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on ti_pkg for the quotient width; the initial remainder must be below the divisor.
module ti_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ti_pkg::QuotWidth-1:0]  rem_init,
    input  logic [ti_pkg::QuotWidth-1:0]  low,
    input  logic [ti_pkg::QuotWidth-1:0]  divisor,
    output logic                          busy,
    output logic                          done,
    output logic [ti_pkg::QuotWidth-1:0]  quot,
    output logic [ti_pkg::QuotWidth-1:0]  rem
);

    localparam int W = ti_pkg::QuotWidth;

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ti_pkg::CntWidth-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  work_reg, work_next;
    logic [W-1:0]                  dvs_reg, dvs_next;
    logic [W:0]                    trial;
    logic [W:0]                    diff;
    logic                          ge;

    // One shift-and-subtract step per cycle.
    always_comb begin
        trial     = {rem_reg, work_reg[W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = rem_init;
            work_next = low;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[W-1:0] : trial[W-1:0];
            work_next = {work_reg[W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ti_pkg::CntWidth'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers are reset; the data registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        work_reg <= work_next;
        dvs_reg  <= dvs_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = work_reg;
    assign rem  = rem_reg;

endmodule

[src/ti_dp.sv]
// Datapath of the trapezoid integrator: sample points, integrand, sum and final scaling.
// Depends on ti_pkg and instantiates the serial divider ti_div.
module ti_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  ti_pkg::cmd_t                          cmd,
    output ti_pkg::sts_t                          sts,
    input  logic signed [ti_pkg::LimitWidth-1:0]  s_lower_limit,
    input  logic signed [ti_pkg::LimitWidth-1:0]  s_upper_limit,
    input  logic        [15:0]                    s_interval_count,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic signed [ti_pkg::ResultWidth-1:0] m_integral
);

    localparam int LW = ti_pkg::LimitWidth;
    localparam int CB = ti_pkg::CountBits;
    localparam int QW = ti_pkg::QuotWidth;
    localparam int DW = LW + 1;
    localparam int SW = 2 * LW - 1;
    localparam int SUMW = 48;
    localparam int PW = QW + DW;

    logic signed [LW-1:0]  lo_reg;
    logic [CB-1:0]         n_reg;
    logic                  neg_reg;
    logic [DW-1:0]         dmag_reg;
    logic [DW-1:0]         stepq_reg;
    logic [CB-1:0]         stepr_reg;
    logic [DW-1:0]         qacc_reg, qacc_next;
    logic [CB:0]           racc_sum;
    logic [CB-1:0]         racc_reg, racc_next;
    logic [CB-1:0]         idx_reg;
    logic [LW-1:0]         mag_reg;
    logic [QW-1:0]         den_reg;
    logic [SUMW-1:0]       sum_reg;
    logic [QW-1:0]         avg_reg;
    logic [PW-1:0]         prod_reg;
    logic                  valid_reg;
    logic [ti_pkg::ResultWidth-1:0] out_reg;

    logic signed [DW:0]    d_full;
    logic signed [LW+1:0]  x_full;
    logic signed [LW+1:0]  off_full;
    logic [SW-1:0]         sq;
    logic [SUMW-1:0]       sn;
    logic [QW:0]           term;
    logic [PW-1:0]         rnd;
    logic [PW-ti_pkg::FxBits-1:0] rmag;
    logic [ti_pkg::ResultWidth-1:0] rounded;
    logic                  last;

    logic [QW-1:0] div_rem_init, div_low, div_divisor, div_quot, div_rem;
    logic          div_busy, div_done;

    // Operand selection for the shared divider.
    always_comb begin
        sn = sum_reg + SUMW'(n_reg);
        case (cmd.div_op)
            ti_pkg::DIV_STEP: begin
                div_rem_init = '0;
                div_low      = QW'(dmag_reg);
                div_divisor  = QW'(n_reg);
            end
            ti_pkg::DIV_INTEG: begin
                div_rem_init = QW'(1) << (ti_pkg::FxBits - (QW - ti_pkg::FracBits));
                div_low      = {1'b0, den_reg[QW-1:1]};
                div_divisor  = den_reg;
            end
            ti_pkg::DIV_MEAN: begin
                div_rem_init = QW'(sn[SUMW-1:QW]);
                div_low      = sn[QW-1:0];
                div_divisor  = QW'({n_reg, 1'b0});
            end
            default: begin
                div_rem_init = '0;
                div_low      = '0;
                div_divisor  = '0;
            end
        endcase
    end

    ti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .rem_init (div_rem_init),
        .low      (div_low),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Sample point, its square and the integrand denominator.
    always_comb begin
        d_full   = (DW+1)'(s_upper_limit) - (DW+1)'(s_lower_limit);
        off_full = neg_reg ? -(LW+2)'(qacc_reg) : (LW+2)'(qacc_reg);
        x_full   = (LW+2)'(lo_reg) + off_full;
        sq       = SW'(mag_reg) * SW'(mag_reg);
        last     = (idx_reg == n_reg);
        term     = (last || idx_reg == '0) ? {1'b0, div_quot} : {div_quot, 1'b0};
        racc_sum = {1'b0, racc_reg} + {1'b0, stepr_reg};
        qacc_next = qacc_reg + stepq_reg;
        racc_next = racc_sum[CB-1:0];
        if (racc_sum >= {1'b0, n_reg}) begin
            qacc_next = qacc_reg + stepq_reg + 1'b1;
            racc_next = CB'(racc_sum - {1'b0, n_reg});
        end
    end

    // Final rounding half away from zero and sign.
    always_comb begin
        rnd     = prod_reg + (PW'(1) << (ti_pkg::FxBits - 1));
        rmag    = rnd[PW-1:ti_pkg::FxBits];
        rounded = neg_reg ? -ti_pkg::ResultWidth'(rmag) : ti_pkg::ResultWidth'(rmag);
    end

    // Datapath registers, loaded under controller command.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lo_reg   <= s_lower_limit;
            n_reg    <= s_interval_count[CB-1:0];
            neg_reg  <= d_full[DW];
            dmag_reg <= d_full[DW] ? DW'(-d_full) : d_full[DW-1:0];
        end
        if (cmd.latch_step) begin
            stepq_reg <= div_quot[DW-1:0];
            stepr_reg <= div_rem[CB-1:0];
            qacc_reg  <= '0;
            racc_reg  <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end
        if (cmd.calc_x) begin
            mag_reg <= x_full[LW+1] ? LW'(-x_full) : x_full[LW-1:0];
        end
        if (cmd.calc_sq) begin
            den_reg <= (QW'(1) << ti_pkg::FracBits) + QW'(sq >> ti_pkg::FracBits);
        end
        if (cmd.accum) begin
            sum_reg <= sum_reg + SUMW'(term);
            if (!last) begin
                idx_reg  <= idx_reg + 1'b1;
                qacc_reg <= qacc_next;
                racc_reg <= racc_next;
            end
        end
        if (cmd.latch_mean) begin
            avg_reg <= div_quot;
        end
        if (cmd.calc_prod) begin
            prod_reg <= PW'(avg_reg) * PW'(dmag_reg);
        end
        if (cmd.load_out) begin
            out_reg <= (n_reg == '0) ? '0 : rounded;
        end
    end

    // Output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign sts.count_zero  = (n_reg == '0);
    assign sts.div_done    = div_done;
    assign sts.div_busy    = div_busy;
    assign sts.last_sample = last;
    assign sts.out_busy    = valid_reg;
    assign m_valid         = valid_reg;
    assign m_integral      = out_reg;

endmodule

[src/ti_ctrl.sv]
// Controller state machine of the trapezoid integrator.
// Depends on ti_pkg; drives the datapath through a command struct.
module ti_ctrl (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         m_ready,
    input  ti_pkg::sts_t sts,
    output ti_pkg::cmd_t cmd
);

    ti_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ti_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_op = ti_pkg::DIV_STEP;
        s_ready    = 1'b0;
        case (state_reg)
            ti_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ti_pkg::ST_STEP_GO;
                end
            end
            ti_pkg::ST_STEP_GO: begin
                if (sts.count_zero) begin
                    state_next = ti_pkg::ST_OUT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ti_pkg::ST_STEP_WAIT;
                end
            end
            ti_pkg::ST_STEP_WAIT: begin
                if (sts.div_done) begin
                    cmd.latch_step = 1'b1;
                    state_next     = ti_pkg::ST_X;
                end
            end
            ti_pkg::ST_X: begin
                cmd.calc_x = 1'b1;
                state_next = ti_pkg::ST_SQ;
            end
            ti_pkg::ST_SQ: begin
                cmd.calc_sq = 1'b1;
                state_next  = ti_pkg::ST_F_GO;
            end
            ti_pkg::ST_F_GO: begin
                cmd.div_op    = ti_pkg::DIV_INTEG;
                cmd.div_start = 1'b1;
                state_next    = ti_pkg::ST_F_WAIT;
            end
            ti_pkg::ST_F_WAIT: begin
                if (sts.div_done) begin
                    cmd.accum  = 1'b1;
                    state_next = sts.last_sample ? ti_pkg::ST_MEAN_GO : ti_pkg::ST_X;
                end
            end
            ti_pkg::ST_MEAN_GO: begin
                cmd.div_op    = ti_pkg::DIV_MEAN;
                cmd.div_start = 1'b1;
                state_next    = ti_pkg::ST_MEAN_WAIT;
            end
            ti_pkg::ST_MEAN_WAIT: begin
                if (sts.div_done) begin
                    cmd.latch_mean = 1'b1;
                    state_next     = ti_pkg::ST_MUL;
                end
            end
            ti_pkg::ST_MUL: begin
                cmd.calc_prod = 1'b1;
                state_next    = ti_pkg::ST_OUT;
            end
            ti_pkg::ST_OUT: begin
                if (!sts.out_busy || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ti_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ti_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[src/trapezoid_integrator.sv]
// Top level of the trapezoid integrator: controller plus datapath.
// Depends on ti_pkg, ti_ctrl, ti_dp and the assertion macro header.
//
// Channel   Direction  Payload
// s_        in         lower_limit, upper_limit (Q7.16), interval_count
// m_        out        integral (Q15.16)
//
// Each of the n+1 sample points of an item waits on the serial divider that
// forms the integrand; a zero count goes from the step state straight to the
// output state and skips the divider. Reset is synchronous and active low.
// One item is worked at a time; a finished result waits in the output register
// and the next item is taken once that result has been loaded there.
`include "trapezoid_integrator_assert.svh"
module trapezoid_integrator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ti_pkg::LimitWidth-1:0]  s_lower_limit,
    input  logic signed [ti_pkg::LimitWidth-1:0]  s_upper_limit,
    input  logic        [15:0]                    s_interval_count,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ti_pkg::ResultWidth-1:0] m_integral
);

    ti_pkg::cmd_t cmd;
    ti_pkg::sts_t sts;

    ti_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ti_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_lower_limit    (s_lower_limit),
        .s_upper_limit    (s_upper_limit),
        .s_interval_count (s_interval_count),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_integral       (m_integral)
    );

    // An accepted item occupies the block for at least the next cycle.
    `TI_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // The divider is never restarted while it is still working.
    `TI_ASSERT_NOW(a_div_not_restarted, cmd.div_start, !sts.div_busy)
    // A result is never loaded over one that is still waiting.
    `TI_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, !m_valid || m_ready)

endmodule

[tb/trapezoid_integrator_test.sv]
// Self-checking testbench for the trapezoid integrator: drives limit/count items,
// predicts each integral in fixed point and checks every result. Depends on ti_pkg.
module trapezoid_integrator_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [ti_pkg::LimitWidth-1:0] lower;
        logic signed [ti_pkg::LimitWidth-1:0] upper;
        logic [15:0]                          count;
    } span_t;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_valid;
    logic                                  s_ready;
    logic signed [ti_pkg::LimitWidth-1:0]  s_lower_limit;
    logic signed [ti_pkg::LimitWidth-1:0]  s_upper_limit;
    logic [15:0]                           s_interval_count;
    logic                                  m_valid;
    logic                                  m_ready;
    logic signed [ti_pkg::ResultWidth-1:0] m_integral;

    span_t                                 pending_spans[$];
    logic signed [ti_pkg::ResultWidth-1:0] expected_integrals[$];
    int unsigned                           gap_left;
    int unsigned                           burst_left;
    int unsigned                           cycle_count;
    int unsigned                           spans_sent;
    int unsigned                           integrals_seen;
    int unsigned                           error_count;

    trapezoid_integrator u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_lower_limit    (s_lower_limit),
        .s_upper_limit    (s_upper_limit),
        .s_interval_count (s_interval_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_integral       (m_integral)
    );

    // Sample of 1/(1+x^2) with FxBits fraction bits, rounded half up.
    function automatic longint unsigned height_at(longint x);
        longint unsigned mag;
        longint unsigned q;
        mag = (x < 0) ? longint'(-x) : longint'(x);
        q = (64'd1 << ti_pkg::FracBits) + ((mag * mag) >> ti_pkg::FracBits);
        return ((64'd1 << (ti_pkg::FracBits + ti_pkg::FxBits)) + (q >> 1)) / q;
    endfunction

    // Trapezoidal estimate of the integral over one span.
    function automatic logic signed [ti_pkg::ResultWidth-1:0] trapezoid_sum(span_t sp);
        longint          lo;
        longint          d;
        longint          n;
        longint unsigned acc;
        longint unsigned mean;
        longint unsigned r;
        longint unsigned f;
        lo = sp.lower;
        d = longint'(sp.upper) - lo;
        n = sp.count[ti_pkg::CountBits-1:0];
        acc = 0;
        if (n == 0) begin
            return '0;
        end
        for (longint i = 0; i <= n; i++) begin
            f = height_at(lo + (i * d) / n);
            acc += (i == 0 || i == n) ? f : (f << 1);
        end
        mean = (acc + n) / (n << 1);
        r = (mean * longint'(d < 0 ? -d : d) + (64'd1 << (ti_pkg::FxBits - 1)))
            >> ti_pkg::FxBits;
        return (d < 0) ? ti_pkg::ResultWidth'(-longint'(r))
                       : ti_pkg::ResultWidth'(longint'(r));
    endfunction

    function automatic span_t rand_span();
        span_t sp;
        sp.lower = ti_pkg::LimitWidth'($urandom);
        // Mostly short spans near the origin, sometimes anywhere in range.
        if ($urandom_range(0, 3) == 0) begin
            sp.upper = ti_pkg::LimitWidth'($urandom);
        end else begin
            sp.lower = $signed(sp.lower) >>> $urandom_range(0, 6);
            sp.upper = ti_pkg::LimitWidth'(sp.lower
                       + $signed(24'($urandom_range(0, 1 << 20))) - (1 << 19));
        end
        sp.count = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(65, 300))
                                                : 16'($urandom_range(0, 64));
        return sp;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Sender: bursts of items separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_lower_limit <= '0;
            s_upper_limit <= '0;
            s_interval_count <= '0;
            gap_left <= 0;
            burst_left <= 1;
            spans_sent <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_integrals.push_back(trapezoid_sum('{s_lower_limit, s_upper_limit,
                                                            s_interval_count}));
                spans_sent <= spans_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_spans.size() > 0) begin
                    span_t sp;
                    sp = pending_spans.pop_front();
                    s_lower_limit <= sp.lower;
                    s_upper_limit <= sp.upper;
                    s_interval_count <= sp.count;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls in alternating windows, on a fixed sub-pattern of the cycle count.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            cycle_count <= 0;
            integrals_seen <= 0;
            error_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            m_ready <= ((cycle_count / 1000) % 2 == 0) || (cycle_count % 11 > 3);
            if (m_valid && m_ready) begin
                integrals_seen <= integrals_seen + 1;
                if (expected_integrals.size() == 0) begin
                    $error("integral: unexpected item, actual %0d", m_integral);
                    error_count <= error_count + 1;
                end else begin
                    logic signed [ti_pkg::ResultWidth-1:0] want;
                    want = expected_integrals.pop_front();
                    if (m_integral !== want) begin
                        $error("integral: expected %0d, actual %0d", want, m_integral);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        aresetn = 1'b0;
        pending_spans.push_back('{24'sd0, 24'sd65536, 16'd0});          // zero count
        pending_spans.push_back('{24'sd65536, 24'sd65536, 16'd5});      // equal limits
        pending_spans.push_back('{24'sd131072, -24'sd131072, 16'd8});   // reversed limits
        pending_spans.push_back('{-24'sd131072, 24'sd131072, 16'd8});
        pending_spans.push_back('{-24'sd8388608, 24'sd8388607, 16'd1});
        pending_spans.push_back('{24'sd8388607, -24'sd8388608, 16'd2});
        pending_spans.push_back('{-24'sd8388608, -24'sd8388608, 16'd3});
        pending_spans.push_back('{24'sd0, 24'sd1, 16'd1});
        pending_spans.push_back('{24'sd0, 24'sd65536, 16'd64});
        pending_spans.push_back('{-24'sd1, 24'sd0, 16'd7});
        pending_spans.push_back('{24'sd8388607, 24'sd8388607, 16'd0});
        pending_spans.push_back('{-24'sd8388608, 24'sd8388607, 16'd65535}); // full count
        for (int k = 0; k < 100; k++) begin
            pending_spans.push_back(rand_span());
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_spans.size() > 0 || s_valid || expected_integrals.size() > 0) begin
            @(posedge aclk);
        end
        repeat (200) @(posedge aclk);
        $display("Ran %0d spans through the integrator, %0d integrals checked,",
                 spans_sent, integrals_seen);
        $display("including zero, equal, reversed and full-range limits and the largest count.");
        if (error_count == 0 && expected_integrals.size() == 0) begin
            $display("PASS trapezoid_integrator");
        end else begin
            $display("FAIL trapezoid_integrator");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #200ms;
        $display("FAIL trapezoid_integrator");
        $finish;
    end
endmodule
